/* rtl/assert_macros.svh */
// Assertion macros for the stepper position controller RTL, used by spc_motion.
// Depends on nothing; users must have clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define SPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/spc_pkg.sv */
// Types and constants for the stepper position controller.
// Used by all RTL modules of the block; depends on nothing.
package spc_pkg;

  localparam int unsigned DataWidth = 16;

  // Item kinds
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_MOVE = 1'b1;

  // Configuration register indexes
  localparam int unsigned CfgIdxWidth = 2;
  localparam logic [CfgIdxWidth-1:0] CFG_MIN_POSITION  = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_MAX_POSITION  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_STEP_INTERVAL = 2'd2;

  // Configuration reset values
  localparam logic signed [DataWidth-1:0] MinPositionRst  = 16'sd0;
  localparam logic signed [DataWidth-1:0] MaxPositionRst  = 16'sd32767;
  localparam logic        [DataWidth-1:0] StepIntervalRst = 16'd2;

  typedef struct packed {
    logic                        cmd;
    logic signed [DataWidth-1:0] target;
  } spc_in_t;

  typedef struct packed {
    logic [3:0]                  coils;
    logic                        drive_enable;
    logic signed [DataWidth-1:0] position;
    logic                        busy_res;
    logic                        stepped;
  } spc_out_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] min_position;
    logic signed [DataWidth-1:0] max_position;
    logic        [DataWidth-1:0] step_interval;
  } spc_cfg_t;

  // Two-phase-on full-step pattern, bit i drives coil i.
  function automatic logic [3:0] phase_pattern(input logic [1:0] phase);
    logic [3:0] pat;
    unique case (phase)
      2'd0: pat = 4'h3;
      2'd1: pat = 4'h6;
      2'd2: pat = 4'hC;
      2'd3: pat = 4'h9;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

endpackage

/* rtl/spc_cfg_regs.sv */
// Configuration register file of the stepper position controller.
// Depends on spc_pkg.
module spc_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_en_i,
  input  logic [spc_pkg::CfgIdxWidth-1:0]   wr_index_i,
  input  logic [spc_pkg::DataWidth-1:0]     wr_data_i,
  output spc_pkg::spc_cfg_t                 cfg_o
);
  import spc_pkg::*;

  spc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        CFG_MIN_POSITION:  cfg_d.min_position  = wr_data_i;
        CFG_MAX_POSITION:  cfg_d.max_position  = wr_data_i;
        CFG_STEP_INTERVAL: cfg_d.step_interval = wr_data_i;
        default: cfg_d = cfg_q; // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_position  <= MinPositionRst;
      cfg_q.max_position  <= MaxPositionRst;
      cfg_q.step_interval <= StepIntervalRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/spc_motion.sv */
// Motion state and per-item update of the stepper position controller.
// Depends on spc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module spc_motion #(
  parameter int unsigned POSITION_WIDTH = 16,
  parameter int unsigned TIMER_WIDTH    = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spc_pkg::spc_cfg_t   cfg_i,
  input  logic                adv_i,
  input  spc_pkg::spc_in_t    item_i,
  output spc_pkg::spc_out_t   res_o
);
  import spc_pkg::*;

  localparam int unsigned CW = (POSITION_WIDTH > DataWidth) ? POSITION_WIDTH : DataWidth;
  localparam int unsigned LW = (TIMER_WIDTH > DataWidth) ? TIMER_WIDTH : DataWidth;
  localparam logic signed [CW-1:0] PosMax =
    {{(CW-POSITION_WIDTH+1){1'b0}}, {(POSITION_WIDTH-1){1'b1}}};
  localparam logic signed [CW-1:0] PosMin = ~PosMax;
  localparam logic [LW-1:0] TimerMax = LW'({TIMER_WIDTH{1'b1}});

  logic signed [POSITION_WIDTH-1:0] cur_q, cur_d, tgt_q, tgt_d;
  logic                             fwd_q, fwd_d, busy_q, busy_d, drv_q, drv_d;
  logic [TIMER_WIDTH-1:0]           cnt_q, cnt_d;
  logic [3:0]                       coil_q, coil_d;
  logic                             stepped;

  logic signed [DataWidth-1:0]      tgt_lim;
  logic signed [CW-1:0]             tgt_ext, tgt_sat, cur_ext;
  logic [LW-1:0]                    ivl_ext, lim_ext;
  logic [TIMER_WIDTH-1:0]           lim, cnt_inc;
  logic                             done;

  // Clamp the target to the limits, lower one checked first, then to the position range.
  always_comb begin
    priority if (item_i.target < cfg_i.min_position) begin
      tgt_lim = cfg_i.min_position;
    end else if (item_i.target > cfg_i.max_position) begin
      tgt_lim = cfg_i.max_position;
    end else begin
      tgt_lim = item_i.target;
    end
    tgt_ext = CW'(tgt_lim);
    priority if (tgt_ext > PosMax) begin
      tgt_sat = PosMax;
    end else if (tgt_ext < PosMin) begin
      tgt_sat = PosMin;
    end else begin
      tgt_sat = tgt_ext;
    end
  end

  // Saturate the interval to what the tick counter can hold.
  always_comb begin
    ivl_ext = LW'(cfg_i.step_interval);
    lim_ext = (ivl_ext > TimerMax) ? TimerMax : ivl_ext;
    lim     = lim_ext[TIMER_WIDTH-1:0];
    cnt_inc = (cnt_q < lim) ? cnt_q + TIMER_WIDTH'(1) : cnt_q;
    done    = fwd_q ? (cur_q >= tgt_q) : (cur_q <= tgt_q);
  end

  always_comb begin
    cur_d   = cur_q;
    tgt_d   = tgt_q;
    fwd_d   = fwd_q;
    busy_d  = busy_q;
    drv_d   = drv_q;
    cnt_d   = cnt_q;
    coil_d  = coil_q;
    stepped = 1'b0;
    unique case (item_i.cmd)
      CMD_MOVE: begin
        tgt_d = tgt_sat[POSITION_WIDTH-1:0];
        if (tgt_d != cur_q) begin
          coil_d = 4'h0;
          drv_d  = 1'b1;
          fwd_d  = tgt_d > cur_q;
          busy_d = 1'b1;
        end
      end
      CMD_TICK: begin
        cnt_d = cnt_inc;
        if (busy_q) begin
          if (done) begin
            drv_d  = 1'b0;
            busy_d = 1'b0;
          end else if (cnt_inc >= lim) begin
            coil_d  = phase_pattern(cur_q[1:0]);
            cur_d   = fwd_q ? cur_q + POSITION_WIDTH'(1) : cur_q - POSITION_WIDTH'(1);
            cnt_d   = '0;
            stepped = 1'b1;
          end
        end
      end
      default: cur_d = cur_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      tgt_q  <= '0;
      fwd_q  <= 1'b0;
      busy_q <= 1'b0;
      drv_q  <= 1'b0;
      cnt_q  <= '0;
      coil_q <= '0;
    end else if (adv_i) begin
      cur_q  <= cur_d;
      tgt_q  <= tgt_d;
      fwd_q  <= fwd_d;
      busy_q <= busy_d;
      drv_q  <= drv_d;
      cnt_q  <= cnt_d;
      coil_q <= coil_d;
    end
  end

  always_comb begin
    cur_ext            = CW'(cur_d);
    res_o.coils        = drv_d ? coil_d : 4'h0;
    res_o.drive_enable = drv_d;
    res_o.position     = cur_ext[DataWidth-1:0];
    res_o.busy_res     = busy_d;
    res_o.stepped      = stepped;
  end

  `SPC_ASSERT(a_busy_has_drive, busy_q |-> drv_q, "busy without drivers enabled")
  `SPC_ASSERT(a_hold_when_idle, !adv_i |=> ($stable(cur_q) && $stable(tgt_q)),
              "motion state changed without an item")
  `SPC_ASSERT(a_no_step_when_idle,
              (adv_i && item_i.cmd == CMD_TICK && !busy_q) |=> $stable(cur_q),
              "position moved on a tick while not busy")

endmodule

/* rtl/stepper_position_controller_top.sv */
// Top level of the stepper position controller: channels, item and result
// registers. Depends on spc_pkg, spc_cfg_regs and spc_motion.
//
// Usage:
//   in channel  : one item per transfer, cmd 0 is a time tick, cmd 1 a move
//                 request with its target position.
//   out channel : exactly one result per item, in item order: coil levels,
//                 driver enable, position, busy flag and step flag.
//   cfg channel : register index and data; always ready. Write only while no
//                 item is in flight.
//   Flow: an accepted item waits in the item register until the result register
//   is free or being drained; it then updates the motion state and its result is
//   taken into the result register.
//   Throughput: one item per cycle while the receiver keeps ready high, set by
//   the single update of the motion state between the item and result registers.
//   Reset: clears the motion state, empties both registers and loads the
//   limits 0 and 32767 and the step interval 2.
//   Stall: while the receiver holds ready low, the result stays put and one
//   more item is still taken into the item register; then input ready drops.
module stepper_position_controller_top #(
  parameter int unsigned POSITION_WIDTH = 16,
  parameter int unsigned TIMER_WIDTH    = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  spc_pkg::spc_in_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output spc_pkg::spc_out_t                out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [spc_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [spc_pkg::DataWidth-1:0]    cfg_data_i
);
  import spc_pkg::*;

  spc_cfg_t cfg;
  spc_in_t  item_q;
  spc_out_t res, res_q;
  logic     item_vld_q, res_vld_q, adv;

  assign cfg_ready_o = 1'b1;

  spc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Advance the held item when the result register is free or being drained.
  assign adv        = item_vld_q && (!res_vld_q || out_ready_i);
  assign in_ready_o = !item_vld_q || adv;

  spc_motion #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .TIMER_WIDTH    (TIMER_WIDTH)
  ) u_motion (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .adv_i  (adv),
    .item_i (item_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        item_vld_q <= in_valid_i;
      end
      if (adv) begin
        res_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    if (adv) begin
      res_q <= res;
    end
  end

  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;

endmodule
